@@ src/pem_pkg.sv @@
package pem_pkg;

	// Field and register widths
	localparam int PIXEL_W    = 8;
	localparam int CFG_W      = 11;
	localparam int CFG_IDX_W  = 2;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

	localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 11'd640;
	localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd480;

	// Gradient datapath: column sums, squares and their sum
	localparam int GSUM_W   = 10;
	localparam int SQ_W     = 20;
	localparam int SQ_SUM_W = 21;

	// Square root unit: 16-bit radicand, 8-bit root, two bits of root per cycle
	localparam int RAD_W           = 16;
	localparam int ROOT_W          = 8;
	localparam int REM_W           = 11;
	localparam int STEPS_PER_CYCLE = 2;
	localparam int ROOT_CYCLES     = ROOT_W / STEPS_PER_CYCLE;
	localparam int STEP_CNT_W      = $clog2(ROOT_CYCLES);

	localparam logic [ROOT_W-1:0] MAG_MAX = 8'd255;

	// Queue depths
	localparam int CMD_DEPTH = 4;
	localparam int RES_DEPTH = 4;

	typedef enum logic {
		KIND_PIXEL = 1'b0,
		KIND_DRAIN = 1'b1
	} kind_t;

	// Command from the front end to the back end
	typedef struct packed {
		kind_t kind;
		logic  first_col;  // column zero: clear the window first
		logic  ge1;        // row above is inside the frame
		logic  ge2;        // row two above is inside the frame
		logic  emit_mid;   // output one column back
		logic  emit_end;   // output at the end of the row above
		logic  last_col;   // last column of the row
	} cmd_t;

	typedef struct packed {
		logic [PIXEL_W-1:0] magnitude;
		logic               end_of_row;
		logic               end_of_frame;
	} res_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_SHIFT,
		ST_ZERO,
		ST_GRAD,
		ST_SQUARE,
		ST_START,
		ST_ROOT,
		ST_PUSH
	} back_state_t;

endpackage

@@ src/pem_fifo.sv @@
module pem_fifo
	import pem_pkg::*;
#(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

endmodule

@@ src/pem_front.sv @@
module pem_front
	import pem_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024,
	localparam int COL_W     = $clog2(MAX_WIDTH)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic                 kind,
	input  logic [PIXEL_W-1:0]   pixel,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 cmd_full,
	output logic                 cmd_push,
	output cmd_t                 cmd,
	output logic [COL_W-1:0]     cmd_col,
	output logic [PIXEL_W-1:0]   cmd_pixel
);

	localparam int WCNT_W = $clog2(MAX_WIDTH + 1);
	localparam int ROW_W  = $clog2(MAX_HEIGHT + 1);

	logic [CFG_W-1:0]  frame_width_q;
	logic [CFG_W-1:0]  frame_height_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [WCNT_W-1:0] width_eff;
	logic [ROW_W-1:0]  height_eff;
	logic              accept;
	logic              last_col;
	logic              pixel_ok;
	logic              drain_ok;

	// Clamp the frame size into the supported range
	always_comb begin
		if (frame_width_q == '0) begin
			width_eff = WCNT_W'(1);
		end else if (32'(frame_width_q) > 32'(MAX_WIDTH)) begin
			width_eff = WCNT_W'(MAX_WIDTH);
		end else begin
			width_eff = WCNT_W'(frame_width_q);
		end
		if (frame_height_q == '0) begin
			height_eff = ROW_W'(1);
		end else if (32'(frame_height_q) > 32'(MAX_HEIGHT)) begin
			height_eff = ROW_W'(MAX_HEIGHT);
		end else begin
			height_eff = ROW_W'(frame_height_q);
		end
	end

	// Classify the incoming item; ignored items make no command
	assign accept   = push && !cmd_full;
	assign last_col = (WCNT_W'(col_q) == width_eff - WCNT_W'(1));
	assign pixel_ok = (kind == KIND_PIXEL) && (row_q < height_eff);
	assign drain_ok = (kind == KIND_DRAIN) && (row_q >= height_eff);
	assign cmd_push = accept && (pixel_ok || drain_ok);

	always_comb begin
		cmd.kind      = kind_t'(kind);
		cmd.first_col = (col_q == '0);
		cmd.last_col  = last_col;
		if (kind == KIND_PIXEL) begin
			cmd.ge1      = (row_q != '0);
			cmd.ge2      = (row_q >= ROW_W'(2));
			cmd.emit_mid = (row_q != '0) && (col_q != '0);
			cmd.emit_end = (row_q != '0) && last_col;
		end else begin
			cmd.ge1      = 1'b1;
			cmd.ge2      = (height_eff >= ROW_W'(2));
			cmd.emit_mid = 1'b0;
			cmd.emit_end = 1'b0;
		end
	end

	assign cmd_col   = col_q;
	assign cmd_pixel = pixel;

	// Write registers and advance the raster position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
			col_q          <= '0;
			row_q          <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_WIDTH: begin
					frame_width_q <= cfg_data;
					col_q         <= '0;
					row_q         <= '0;
				end
				REG_FRAME_HEIGHT: begin
					frame_height_q <= cfg_data;
					col_q          <= '0;
					row_q          <= '0;
				end
				default: begin
				end
			endcase
		end else if (accept && pixel_ok) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end else if (accept && drain_ok) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= '0;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		WCNT_W'(col_q) < width_eff)
		else $error("column position beyond the row");

	a_row_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= height_eff)
		else $error("row position beyond the frame");

endmodule

@@ src/pem_isqrt.sv @@
module pem_isqrt
	import pem_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [SQ_SUM_W-1:0] operand,
	output logic                done,
	output logic [ROOT_W-1:0]   root
);

	logic                  busy_q;
	logic                  done_q;
	logic [STEP_CNT_W-1:0] cnt_q;
	logic                  sat_q;
	logic [RAD_W-1:0]      op_q;
	logic [RAD_W-1:0]      rad_q;
	logic [REM_W-1:0]      rem_q;
	logic [ROOT_W-1:0]     root_q;
	logic [RAD_W-1:0]      rad_v;
	logic [REM_W-1:0]      rem_v;
	logic [REM_W-1:0]      trial_v;
	logic [ROOT_W-1:0]     root_v;

	// Restoring root, two digits of the radicand per step
	always_comb begin
		rad_v   = rad_q;
		rem_v   = rem_q;
		root_v  = root_q;
		trial_v = '0;
		for (int i = 0; i < STEPS_PER_CYCLE; i++) begin
			rem_v   = {rem_v[REM_W-3:0], rad_v[RAD_W-1 -: 2]};
			rad_v   = {rad_v[RAD_W-3:0], 2'b00};
			trial_v = {1'b0, root_v, 2'b01};
			if (rem_v >= trial_v) begin
				rem_v  = rem_v - trial_v;
				root_v = {root_v[ROOT_W-2:0], 1'b1};
			end else begin
				root_v = {root_v[ROOT_W-2:0], 1'b0};
			end
		end
	end

	// Sequence the iterations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == STEP_CNT_W'(ROOT_CYCLES - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Load the radicand, then iterate
	always_ff @(posedge clk) begin
		if (start) begin
			sat_q  <= |operand[SQ_SUM_W-1:RAD_W];
			op_q   <= operand[RAD_W-1:0];
			rad_q  <= operand[RAD_W-1:0];
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= rad_v;
			rem_q  <= rem_v;
			root_q <= root_v;
		end
	end

	assign done = done_q;
	assign root = sat_q ? MAG_MAX : root_q;

	a_root_exact: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && !sat_q |->
			(32'(root_q) * 32'(root_q) <= 32'(op_q)) &&
			((32'(root_q) + 32'd1) * (32'(root_q) + 32'd1) > 32'(op_q)))
		else $error("square root is not the floor root");

endmodule

@@ src/pem_back.sv @@
module pem_back
	import pem_pkg::*;
#(
	parameter int MAX_WIDTH = 1024,
	localparam int COL_W    = $clog2(MAX_WIDTH)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_empty,
	input  cmd_t               cmd,
	input  logic [COL_W-1:0]   cmd_col,
	input  logic [PIXEL_W-1:0] cmd_pixel,
	output logic               cmd_pop,
	input  logic               res_full,
	output logic               res_push,
	output res_t               res
);

	back_state_t state_q;
	back_state_t state_d;

	cmd_t               cmd_q;
	logic               second_q;
	logic               end_due_q;
	logic               eor_q;
	logic               eof_q;
	logic [COL_W-1:0]   addr_q;
	logic [PIXEL_W-1:0] pix_q;

	logic [PIXEL_W-1:0] row_above_q     [MAX_WIDTH];
	logic [PIXEL_W-1:0] row_two_above_q [MAX_WIDTH];
	logic [PIXEL_W-1:0] above_rd_q;
	logic [PIXEL_W-1:0] two_rd_q;

	logic [PIXEL_W-1:0] win_q [3][3];
	logic [PIXEL_W-1:0] col_in [3];
	logic               shift_en;
	logic               shift_clear;
	logic               store_we;

	logic [GSUM_W-1:0]   sum_right;
	logic [GSUM_W-1:0]   sum_left;
	logic [GSUM_W-1:0]   sum_bottom;
	logic [GSUM_W-1:0]   sum_top;
	logic [GSUM_W-1:0]   gx_s1;
	logic [GSUM_W-1:0]   gy_s1;
	logic [SQ_W-1:0]     sqx_s2;
	logic [SQ_W-1:0]     sqy_s2;
	logic                root_start;
	logic                root_done;
	logic [ROOT_W-1:0]   root;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (!cmd_empty) begin
					if (cmd.kind == KIND_DRAIN && !cmd.first_col && cmd.last_col) begin
						state_d = ST_ZERO;
					end else begin
						state_d = ST_READ;
					end
				end
			end
			ST_READ: state_d = ST_SHIFT;
			ST_SHIFT: begin
				if (cmd_q.kind == KIND_PIXEL) begin
					if (cmd_q.emit_mid) begin
						state_d = ST_GRAD;
					end else if (cmd_q.emit_end) begin
						state_d = ST_ZERO;
					end else begin
						state_d = ST_IDLE;
					end
				end else if (cmd_q.first_col && !second_q) begin
					state_d = cmd_q.last_col ? ST_ZERO : ST_READ;
				end else begin
					state_d = ST_GRAD;
				end
			end
			ST_ZERO:   state_d = ST_GRAD;
			ST_GRAD:   state_d = ST_SQUARE;
			ST_SQUARE: state_d = ST_START;
			ST_START:  state_d = ST_ROOT;
			ST_ROOT: begin
				if (root_done) begin
					state_d = ST_PUSH;
				end
			end
			ST_PUSH: begin
				if (!res_full) begin
					state_d = end_due_q ? ST_ZERO : ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		cmd_pop     = (state_q == ST_IDLE) && !cmd_empty;
		store_we    = (state_q == ST_SHIFT) && (cmd_q.kind == KIND_PIXEL);
		shift_en    = (state_q == ST_SHIFT) || (state_q == ST_ZERO);
		shift_clear = (state_q == ST_SHIFT) && cmd_q.first_col && !second_q;
		root_start  = (state_q == ST_START);
		res_push    = (state_q == ST_PUSH) && !res_full;
		if (state_q == ST_SHIFT) begin
			col_in[0] = cmd_q.ge2 ? two_rd_q : '0;
			col_in[1] = cmd_q.ge1 ? above_rd_q : '0;
			col_in[2] = (cmd_q.kind == KIND_PIXEL) ? pix_q : '0;
		end else begin
			col_in[0] = '0;
			col_in[1] = '0;
			col_in[2] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Hold the command and its result flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q     <= '0;
			second_q  <= 1'b0;
			end_due_q <= 1'b0;
			eor_q     <= 1'b0;
			eof_q     <= 1'b0;
		end else if (cmd_pop) begin
			cmd_q     <= cmd;
			second_q  <= 1'b0;
			end_due_q <= (cmd.kind == KIND_PIXEL) && cmd.emit_end;
			eor_q     <= (cmd.kind == KIND_DRAIN) && cmd.last_col;
			eof_q     <= (cmd.kind == KIND_DRAIN) && cmd.last_col;
		end else if (state_q == ST_SHIFT && cmd_q.kind == KIND_DRAIN &&
				cmd_q.first_col && !second_q && !cmd_q.last_col) begin
			second_q <= 1'b1;
		end else if (state_q == ST_ZERO && cmd_q.kind == KIND_PIXEL) begin
			eor_q     <= 1'b1;
			end_due_q <= 1'b0;
		end
	end

	// Line store address and pixel
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			pix_q  <= cmd_pixel;
			addr_q <= (cmd.kind == KIND_DRAIN && !cmd.first_col) ? cmd_col + 1'b1 : cmd_col;
		end else if (state_q == ST_SHIFT && cmd_q.kind == KIND_DRAIN &&
				cmd_q.first_col && !second_q) begin
			addr_q <= addr_q + 1'b1;
		end
	end

	// Line stores: one read and one write port each
	always_ff @(posedge clk) begin
		if (store_we) begin
			row_above_q[addr_q]     <= pix_q;
			row_two_above_q[addr_q] <= above_rd_q;
		end
		above_rd_q <= row_above_q[addr_q];
		two_rd_q   <= row_two_above_q[addr_q];
	end

	// Shift a new column into the window
	always_ff @(posedge clk) begin
		if (shift_en) begin
			for (int r = 0; r < 3; r++) begin
				if (shift_clear) begin
					win_q[r][0] <= '0;
					win_q[r][1] <= '0;
				end else begin
					win_q[r][0] <= win_q[r][1];
					win_q[r][1] <= win_q[r][2];
				end
				win_q[r][2] <= col_in[r];
			end
		end
	end

	// Column and row sums of the window
	assign sum_right  = GSUM_W'(win_q[0][2]) + GSUM_W'(win_q[1][2]) + GSUM_W'(win_q[2][2]);
	assign sum_left   = GSUM_W'(win_q[0][0]) + GSUM_W'(win_q[1][0]) + GSUM_W'(win_q[2][0]);
	assign sum_bottom = GSUM_W'(win_q[2][0]) + GSUM_W'(win_q[2][1]) + GSUM_W'(win_q[2][2]);
	assign sum_top    = GSUM_W'(win_q[0][0]) + GSUM_W'(win_q[0][1]) + GSUM_W'(win_q[0][2]);

	// Absolute gradients, then their squares
	always_ff @(posedge clk) begin
		if (state_q == ST_GRAD) begin
			gx_s1 <= (sum_right >= sum_left) ? sum_right - sum_left : sum_left - sum_right;
			gy_s1 <= (sum_bottom >= sum_top) ? sum_bottom - sum_top : sum_top - sum_bottom;
		end
		if (state_q == ST_SQUARE) begin
			sqx_s2 <= SQ_W'(gx_s1) * SQ_W'(gx_s1);
			sqy_s2 <= SQ_W'(gy_s1) * SQ_W'(gy_s1);
		end
	end

	pem_isqrt u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (root_start),
		.operand (SQ_SUM_W'(sqx_s2) + SQ_SUM_W'(sqy_s2)),
		.done    (root_done),
		.root    (root)
	);

	assign res.magnitude    = root;
	assign res.end_of_row   = eor_q;
	assign res.end_of_frame = eof_q;

	a_root_awaited: assert property (@(posedge clk) disable iff (!arst_n)
		root_done |-> state_q == ST_ROOT)
		else $error("square root finished while not awaited");

	a_second_read_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SHIFT && cmd_q.kind == KIND_DRAIN && second_q |-> !cmd_q.last_col)
		else $error("drain read a column past the row");

	a_frame_end_is_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res.end_of_frame || res.end_of_row)
		else $error("end of frame without end of row");

endmodule

@@ src/prewitt_edge_magnitude.sv @@
// Prewitt gradient magnitude over a 3x3 window, streamed in raster order.
// The back end handles one command at a time: it reads the line stores, squares the
// gradients and runs a square root for each result, while the command queue keeps
// taking new items until it is full.
// Reset (arst_n low): registers return to 640 x 480, queues empty; line stores keep data.
module prewitt_edge_magnitude
	import pem_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic                 kind,
	input  logic [PIXEL_W-1:0]   pixel,
	output logic                 empty,
	input  logic                 pop,
	output logic [PIXEL_W-1:0]   magnitude,
	output logic                 end_of_row,
	output logic                 end_of_frame,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int CMD_W = $bits(cmd_t) + COL_W + PIXEL_W;
	localparam int RES_W = $bits(res_t);

	logic               front_push;
	cmd_t               front_cmd;
	logic [COL_W-1:0]   front_col;
	logic [PIXEL_W-1:0] front_pixel;
	logic               cmd_full;
	logic               cmd_empty;
	logic               cmd_pop;
	logic [CMD_W-1:0]   cmd_dout;
	cmd_t               back_cmd;
	logic [COL_W-1:0]   back_col;
	logic [PIXEL_W-1:0] back_pixel;
	logic               res_push;
	logic               res_full;
	res_t               back_res;
	logic [RES_W-1:0]   res_dout;
	res_t               out_res;

	pem_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.kind      (kind),
		.pixel     (pixel),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd_full  (cmd_full),
		.cmd_push  (front_push),
		.cmd       (front_cmd),
		.cmd_col   (front_col),
		.cmd_pixel (front_pixel)
	);

	// Command queue between front and back
	pem_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (CMD_DEPTH)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (front_push),
		.din    ({front_cmd, front_col, front_pixel}),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.dout   (cmd_dout),
		.empty  (cmd_empty)
	);

	assign {back_cmd, back_col, back_pixel} = cmd_dout;

	pem_back #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd       (back_cmd),
		.cmd_col   (back_col),
		.cmd_pixel (back_pixel),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (back_res)
	);

	// Result queue toward the consumer
	pem_fifo #(
		.WIDTH (RES_W),
		.DEPTH (RES_DEPTH)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (back_res),
		.full   (res_full),
		.pop    (pop),
		.dout   (res_dout),
		.empty  (empty)
	);

	assign full         = cmd_full;
	assign out_res      = res_dout;
	assign magnitude    = out_res.magnitude;
	assign end_of_row   = out_res.end_of_row;
	assign end_of_frame = out_res.end_of_frame;

endmodule
